>>> hdl/batch_dispatch_with_timeout_unit_defines.svh
// ---------------------------------------------------------------------------
// batch dispatch with timeout - assertion macros
// shorthand for the clocked checks in the port checker
// ---------------------------------------------------------------------------
`ifndef BATCH_DISPATCH_WITH_TIMEOUT_UNIT_DEFINES_SVH
`define BATCH_DISPATCH_WITH_TIMEOUT_UNIT_DEFINES_SVH

// same-cycle implication, muted during reset
`define BDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, muted during reset
`define BDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also runs through reset
`define BDT_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/bdt_pkg.sv
// ---------------------------------------------------------------------------
// bdt_pkg
// widths, register indexes, timeout table and divider request types
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdt_pkg;

  localparam int NUM_QUEUES = 4;
  localparam int QIDX_W     = 2;
  localparam int OCC_W      = 7;
  localparam int TIME_W     = 63;
  localparam int TMO_W      = 28;
  localparam int LVL_W      = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_POLL_ENABLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TMO_LEVEL   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BATCH   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BATCH   = 8'd3;

  typedef struct packed {
    logic             start;
    logic [OCC_W-1:0] dividend;
    logic [OCC_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [OCC_W-1:0] quotient;
  } div_rsp_t;

  // level zero has no meaning and falls back to the fastest entry
  function automatic logic [TMO_W-1:0] timeout_ns(input logic [LVL_W-1:0] lvl);
    logic [TMO_W-1:0] t;
    case (lvl)
      3'd1:    t = 28'd200000000;
      3'd2:    t = 28'd100000000;
      3'd3:    t = 28'd50000000;
      3'd4:    t = 28'd25000000;
      3'd5:    t = 28'd16666667;
      3'd6:    t = 28'd12500000;
      default: t = 28'd10000000;
    endcase
    return t;
  endfunction

endpackage

>>> hdl/bdt_div.sv
// ---------------------------------------------------------------------------
// bdt_div
// restoring divider, one quotient bit per cycle, shared by all queues
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdt_div (
  input  logic               clk,
  input  logic               rst,
  input  bdt_pkg::div_req_t  req,
  output bdt_pkg::div_rsp_t  rsp
);

  localparam int W     = bdt_pkg::OCC_W;
  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     dvd;
  logic [W-1:0]     dsr;

  logic [W:0] trial;
  logic [W:0] diff;
  logic       fits;

  assign trial = {rem, dvd[W-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where the dividend bits shift out
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[W-1:0] : trial[W-1:0];
      dvd <= {dvd[W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

>>> hdl/batch_dispatch_with_timeout_unit.sv
// path: polling disabled, a request goes from IDLE via DONE to the output register;
// else one step per queue, with the 7-step shared divider run for each full queue
// flow: one request in flight; DONE waits until the output register is free
// a finished result waits in the output register while the next request is taken
// reset (rst, synchronous): last-service times cleared, polling off, level 7,
// max_batch and min_batch 8, no result pending
// ---------------------------------------------------------------------------
// batch_dispatch_with_timeout_unit
// polls four request queues and decides how many batches each one dispatches
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module batch_dispatch_with_timeout_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bdt_pkg::TIME_W-1:0]      now_ns,
  input  logic [bdt_pkg::OCC_W-1:0]       occ_rsa_priv,
  input  logic [bdt_pkg::OCC_W-1:0]       occ_rsa_pub,
  input  logic [bdt_pkg::OCC_W-1:0]       occ_keygen,
  input  logic [bdt_pkg::OCC_W-1:0]       occ_derive,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            accepted,
  output logic [bdt_pkg::OCC_W-1:0]       batches_rsa_priv,
  output logic [bdt_pkg::OCC_W-1:0]       batches_rsa_pub,
  output logic [bdt_pkg::OCC_W-1:0]       batches_keygen,
  output logic [bdt_pkg::OCC_W-1:0]       batches_derive
);

  localparam int NQ     = bdt_pkg::NUM_QUEUES;
  localparam int QW     = bdt_pkg::QIDX_W;
  localparam int OW     = bdt_pkg::OCC_W;
  localparam int TW     = bdt_pkg::TIME_W;
  localparam int TMW    = bdt_pkg::TMO_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                state;
  logic                      poll_enable;
  logic [bdt_pkg::LVL_W-1:0] tmo_level;
  logic [OW-1:0]             max_batch;
  logic [OW-1:0]             min_batch;

  logic [TW-1:0]  now_q;
  logic [OW-1:0]  occ_q    [NQ];
  logic [TW-1:0]  last_svc [NQ];
  logic [OW-1:0]  bat      [NQ];
  logic [QW-1:0]  qidx;
  logic           acc_q;

  logic [OW-1:0]  occ_cur;
  logic [TW-1:0]  last_cur;
  logic           full;
  logic [TW:0]    gap;
  logic           elapsed;
  logic           last_q;

  bdt_pkg::div_req_t div_req;
  bdt_pkg::div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  assign occ_cur  = occ_q[qidx];
  assign last_cur = last_svc[qidx];
  assign full     = occ_cur >= max_batch;
  assign last_q   = (qidx == QW'(NQ - 1));

  // shared compare: borrow means the clock went back past the last service
  assign gap     = {1'b0, now_q} - {1'b0, last_cur};
  assign elapsed = gap[TW] ||
                   (gap[TW-1:0] >= {{(TW-TMW){1'b0}}, bdt_pkg::timeout_ns(tmo_level)});

  assign div_req.start    = (state == S_EVAL) && full;
  assign div_req.dividend = occ_cur;
  assign div_req.divisor  = (min_batch == '0) ? OW'(1) : min_batch;

  bdt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      poll_enable <= 1'b0;
      tmo_level   <= 3'd7;
      max_batch   <= 7'd8;
      min_batch   <= 7'd8;
      out_valid   <= 1'b0;
      qidx        <= '0;
      for (int i = 0; i < NQ; i++) begin
        last_svc[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bdt_pkg::REG_POLL_ENABLE: poll_enable <= cfg_data[0];
          bdt_pkg::REG_TMO_LEVEL:   tmo_level   <= cfg_data[bdt_pkg::LVL_W-1:0];
          bdt_pkg::REG_MAX_BATCH:   max_batch   <= cfg_data;
          bdt_pkg::REG_MIN_BATCH:   min_batch   <= cfg_data;
          default: ;
        endcase
      end

      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            qidx  <= '0;
            state <= poll_enable ? S_EVAL : S_DONE;
          end
        end
        S_EVAL: begin
          if (full) begin
            state <= S_DIV;
          end else begin
            if ((occ_cur != '0) && elapsed) begin
              last_svc[qidx] <= now_q;
            end
            qidx  <= qidx + 1'b1;
            state <= last_q ? S_DONE : S_EVAL;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            last_svc[qidx] <= now_q;
            qidx           <= qidx + 1'b1;
            state          <= last_q ? S_DONE : S_EVAL;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request capture and per-queue batch counts
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      now_q    <= now_ns;
      occ_q[0] <= occ_rsa_priv;
      occ_q[1] <= occ_rsa_pub;
      occ_q[2] <= occ_keygen;
      occ_q[3] <= occ_derive;
      acc_q    <= poll_enable;
      for (int i = 0; i < NQ; i++) begin
        bat[i] <= '0;
      end
    end else if (state == S_EVAL && !full) begin
      bat[qidx] <= ((occ_cur != '0) && elapsed) ? OW'(1) : '0;
    end else if (state == S_DIV && div_rsp.done) begin
      bat[qidx] <= div_rsp.quotient;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      accepted         <= acc_q;
      batches_rsa_priv <= bat[0];
      batches_rsa_pub  <= bat[1];
      batches_keygen   <= bat[2];
      batches_derive   <= bat[3];
    end
  end

endmodule

>>> hdl/bdt_checker.sv
// ---------------------------------------------------------------------------
// bdt_checker
// port-level checks on the batch dispatch unit, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "batch_dispatch_with_timeout_unit_defines.svh"

module bdt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [bdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [bdt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [bdt_pkg::TIME_W-1:0]      now_ns,
  input logic [bdt_pkg::OCC_W-1:0]       occ_rsa_priv,
  input logic [bdt_pkg::OCC_W-1:0]       occ_rsa_pub,
  input logic [bdt_pkg::OCC_W-1:0]       occ_keygen,
  input logic [bdt_pkg::OCC_W-1:0]       occ_derive,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            accepted,
  input logic [bdt_pkg::OCC_W-1:0]       batches_rsa_priv,
  input logic [bdt_pkg::OCC_W-1:0]       batches_rsa_pub,
  input logic [bdt_pkg::OCC_W-1:0]       batches_keygen,
  input logic [bdt_pkg::OCC_W-1:0]       batches_derive
);

  // a stalled result keeps its payload
  `BDT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(accepted) && $stable(batches_rsa_priv) && $stable(batches_rsa_pub) && $stable(batches_keygen) && $stable(batches_derive), "stalled result changed")

  // a rejected poll dispatches nothing
  `BDT_ASSERT_NOW(a_reject_empty, out_valid && !accepted, batches_rsa_priv == '0 && batches_rsa_pub == '0 && batches_keygen == '0 && batches_derive == '0, "rejected poll carries batches")

  // only one request in flight
  `BDT_ASSERT_NEXT(a_single_flight, in_valid && in_ready, !in_ready, "request taken while busy")

  // after reset the unit is idle with nothing pending
  `BDT_ASSERT_ALWAYS(a_reset_idle, rst, !out_valid && in_ready, "not idle after reset")

endmodule

bind batch_dispatch_with_timeout_unit bdt_checker u_bdt_checker (.*);
